/* rtl/core/bsmg_pkg.sv */
// Shared types and constants of the bounded set min/max gap unit.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package bsmg_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 11;
  localparam int MODE_W = 2;
  localparam int STAT_W = 2;

  localparam logic [CNT_W-1:0]  RESET_CAPACITY = 11'd10;
  localparam logic [DATA_W-1:0] SIGN_BIAS      = 32'h8000_0000;

  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RANGE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] ST_TOO_FEW  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic              add_wr;     // write the input value at the fill point
    logic              rng_load;   // latch range start and end
    logic              rng_wr;     // write current range value, advance
    logic              q_init;     // start a query pass
    logic              rd_i;       // read outer element, reload inner index
    logic              ld_ai;      // latch outer element from read data
    logic              rd_j;       // read inner element, advance
    logic              inc_i;      // next outer element
    logic              set_res;    // record result status
    logic [STAT_W-1:0] res_status;
    logic              res_span;   // spans are valid for this result
    logic              out_load;   // move result into output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic room;
    logic rng_empty;
    logic too_few;
    logic rng_last;
    logic i_last;
    logic j_last;
    logic out_free;
  } dp_sts_t;

endpackage

/* rtl/core/bounded_set_min_max_gap_unit.sv */
// Bounded set min/max gap unit. Single add, unused mode, empty range, too-few
// query: result set at accept, moved to the output register from the finish
// state. A new item is taken only when idle. A range writes its values one by
// one; query time is set by the pairwise scan through the single read port.
// Async active-low reset: count 0, capacity 10; the store is not cleared.
module bounded_set_min_max_gap_unit #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bsmg_pkg::CNT_W-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [bsmg_pkg::MODE_W-1:0]        mode_i,
  input  logic signed [bsmg_pkg::DATA_W-1:0] value_i,
  input  logic signed [bsmg_pkg::DATA_W-1:0] range_end_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [bsmg_pkg::STAT_W-1:0]        status_o,
  output logic [bsmg_pkg::DATA_W-1:0]        shortest_span_o,
  output logic [bsmg_pkg::DATA_W-1:0]        longest_span_o,
  output logic [bsmg_pkg::CNT_W-1:0]         stored_count_o
);

  bsmg_pkg::dp_cmd_t cmd;
  bsmg_pkg::dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  bsmg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bsmg_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .value_i         (value_i),
    .range_end_i     (range_end_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .shortest_span_o (shortest_span_o),
    .longest_span_o  (longest_span_o),
    .stored_count_o  (stored_count_o)
  );

endmodule

/* rtl/core/bsmg_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module bsmg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* rtl/core/bsmg_ctrl.sv */
// Sequencer of the bounded set min/max gap unit: item decode, range fill
// and the pairwise query scan. Depends on bsmg_pkg.
module bsmg_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [bsmg_pkg::MODE_W-1:0] mode_i,
  input  bsmg_pkg::dp_sts_t        sts_i,
  output bsmg_pkg::dp_cmd_t        cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RNG   = 3'd1;
  localparam logic [2:0] S_QRDI  = 3'd2;
  localparam logic [2:0] S_QLDI  = 3'd3;
  localparam logic [2:0] S_QSCAN = 3'd4;
  localparam logic [2:0] S_DR1   = 3'd5;
  localparam logic [2:0] S_DR2   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (mode_i)
            bsmg_pkg::MODE_ADD: begin
              cmd_o.add_wr     = sts_i.room;
              cmd_o.set_res    = 1'b1;
              cmd_o.res_status = sts_i.room ? bsmg_pkg::ST_OK : bsmg_pkg::ST_OVERFLOW;
              state_d          = S_FIN;
            end
            bsmg_pkg::MODE_RANGE: begin
              if (sts_i.rng_empty) begin
                cmd_o.set_res    = 1'b1;
                cmd_o.res_status = bsmg_pkg::ST_OK;
                state_d          = S_FIN;
              end else begin
                cmd_o.rng_load = 1'b1;
                state_d        = S_RNG;
              end
            end
            bsmg_pkg::MODE_QUERY: begin
              if (sts_i.too_few) begin
                cmd_o.set_res    = 1'b1;
                cmd_o.res_status = bsmg_pkg::ST_TOO_FEW;
                state_d          = S_FIN;
              end else begin
                cmd_o.q_init = 1'b1;
                state_d      = S_QRDI;
              end
            end
            default: begin
              cmd_o.set_res    = 1'b1;
              cmd_o.res_status = bsmg_pkg::ST_OK;
              state_d          = S_FIN;
            end
          endcase
        end
      end
      S_RNG: begin
        if (!sts_i.room) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = bsmg_pkg::ST_OVERFLOW;
          state_d          = S_FIN;
        end else begin
          cmd_o.rng_wr = 1'b1;
          if (sts_i.rng_last) begin
            cmd_o.set_res    = 1'b1;
            cmd_o.res_status = bsmg_pkg::ST_OK;
            state_d          = S_FIN;
          end
        end
      end
      S_QRDI: begin
        cmd_o.rd_i = 1'b1;
        state_d    = S_QLDI;
      end
      S_QLDI, S_QSCAN: begin
        cmd_o.ld_ai = (state_q == S_QLDI);
        cmd_o.rd_j  = 1'b1;
        if (sts_i.j_last) begin
          if (sts_i.i_last) begin
            state_d = S_DR1;
          end else begin
            cmd_o.inc_i = 1'b1;
            state_d     = S_QRDI;
          end
        end else begin
          state_d = S_QSCAN;
        end
      end
      // last read data, then last gap, still in flight
      S_DR1: begin
        state_d = S_DR2;
      end
      S_DR2: begin
        cmd_o.set_res    = 1'b1;
        cmd_o.res_status = bsmg_pkg::ST_OK;
        cmd_o.res_span   = 1'b1;
        state_d          = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/bsmg_datapath.sv */
// Datapath of the bounded set min/max gap unit: value store, counters,
// gap and extreme tracking, output register. Depends on bsmg_pkg, bsmg_ram.
module bsmg_datapath #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [bsmg_pkg::CNT_W-1:0]        cfg_data_i,
  input  logic signed [bsmg_pkg::DATA_W-1:0] value_i,
  input  logic signed [bsmg_pkg::DATA_W-1:0] range_end_i,
  input  bsmg_pkg::dp_cmd_t                 cmd_i,
  output bsmg_pkg::dp_sts_t                 sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bsmg_pkg::STAT_W-1:0]       status_o,
  output logic [bsmg_pkg::DATA_W-1:0]       shortest_span_o,
  output logic [bsmg_pkg::DATA_W-1:0]       longest_span_o,
  output logic [bsmg_pkg::CNT_W-1:0]        stored_count_o
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = bsmg_pkg::CNT_W;
  localparam int DW = bsmg_pkg::DATA_W;
  localparam logic [31:0] MAX_W = 32'(MAX_ENTRIES);

  logic [CW-1:0] cap_q, cnt_q, i_q, j_q;
  logic [CW-1:0] cap_eff;
  logic signed [DW-1:0] cur_q, end_q;
  logic [DW-1:0] ai_q, kmin_q, kmax_q, gmin_q, diff_q;
  logic          rdv_q, dv_q, out_valid_q;
  logic [bsmg_pkg::STAT_W-1:0] res_status_q;
  logic          res_span_q;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata, rkey;

  // capacity above the store depth is clipped to the depth
  assign cap_eff = (32'(cap_q) < MAX_W) ? cap_q : CW'(MAX_ENTRIES);

  assign sts_o.room      = (cnt_q < cap_eff);
  assign sts_o.rng_empty = (value_i > range_end_i);
  assign sts_o.too_few   = (cnt_q < CW'(2));
  assign sts_o.rng_last  = (cur_q == end_q);
  assign sts_o.i_last    = (i_q == CW'(cnt_q - CW'(2)));
  assign sts_o.j_last    = (j_q == CW'(cnt_q - CW'(1)));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign we    = cmd_i.add_wr || cmd_i.rng_wr;
  assign waddr = AW'(cnt_q);
  assign wdata = cmd_i.add_wr ? value_i : cur_q;
  assign raddr = cmd_i.rd_i ? AW'(i_q) : AW'(j_q);

  bsmg_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_i || cmd_i.rd_j),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // biased keys order as unsigned numbers
  assign rkey = rdata ^ bsmg_pkg::SIGN_BIAS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= bsmg_pkg::RESET_CAPACITY;
      cnt_q       <= '0;
      rdv_q       <= 1'b0;
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (we) begin
        cnt_q <= CW'(cnt_q + CW'(1));
      end
      rdv_q <= cmd_i.rd_j;
      dv_q  <= rdv_q;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rng_load) begin
      cur_q <= value_i;
      end_q <= range_end_i;
    end else if (cmd_i.rng_wr) begin
      cur_q <= cur_q + 32'sd1;
    end
    if (cmd_i.q_init) begin
      i_q <= '0;
    end else if (cmd_i.inc_i) begin
      i_q <= CW'(i_q + CW'(1));
    end
    if (cmd_i.rd_i) begin
      j_q <= CW'(i_q + CW'(1));
    end else if (cmd_i.rd_j) begin
      j_q <= CW'(j_q + CW'(1));
    end
    if (cmd_i.ld_ai) begin
      ai_q <= rkey;
    end
    if (cmd_i.q_init) begin
      kmin_q <= '1;
      kmax_q <= '0;
    end else if (cmd_i.ld_ai || rdv_q) begin
      if (rkey < kmin_q) begin
        kmin_q <= rkey;
      end
      if (rkey > kmax_q) begin
        kmax_q <= rkey;
      end
    end
    if (rdv_q) begin
      diff_q <= (rkey >= ai_q) ? (rkey - ai_q) : (ai_q - rkey);
    end
    if (cmd_i.q_init) begin
      gmin_q <= '1;
    end else if (dv_q && (diff_q < gmin_q)) begin
      gmin_q <= diff_q;
    end
    if (cmd_i.set_res) begin
      res_status_q <= cmd_i.res_status;
      res_span_q   <= cmd_i.res_span;
    end
    if (cmd_i.out_load) begin
      status_o        <= res_status_q;
      shortest_span_o <= res_span_q ? gmin_q : '0;
      longest_span_o  <= res_span_q ? (kmax_q - kmin_q) : '0;
      stored_count_o  <= cnt_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/core/bsmg_checker.sv */
// Port-level checks of the bounded set min/max gap unit, bound to the top.
// Depends on bsmg_pkg.
module bsmg_checker #(
  parameter int MAX_ENTRIES = 1024
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [bsmg_pkg::STAT_W-1:0]        status_o,
  input logic [bsmg_pkg::DATA_W-1:0]        shortest_span_o,
  input logic [bsmg_pkg::DATA_W-1:0]        longest_span_o,
  input logic [bsmg_pkg::CNT_W-1:0]         stored_count_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(shortest_span_o) && $stable(longest_span_o)
      && $stable(stored_count_o))
    else $error("result beat changed while stalled");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(stored_count_o) <= 32'(MAX_ENTRIES))
    else $error("stored count above store depth");

  a_too_few: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == bsmg_pkg::ST_TOO_FEW) |->
      (stored_count_o < 11'd2) && (shortest_span_o == '0) && (longest_span_o == '0))
    else $error("too-few status with two or more values or nonzero spans");

  // the smallest neighbor gap never exceeds max minus min
  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> shortest_span_o <= longest_span_o)
    else $error("shortest span above longest span");

endmodule

bind bounded_set_min_max_gap_unit bsmg_checker #(
  .MAX_ENTRIES (MAX_ENTRIES)
) u_bsmg_checker (.*);
